// ===== hdl/pnc_pkg.sv =====
// ----------------------------------------------------------------------------
// pnc_pkg
// shared types, codes and the microprogram of the perfect number checker
// ----------------------------------------------------------------------------
package pnc_pkg;

   localparam int STEP_WIDTH = 3;
   localparam int SUM_WIDTH  = 18;

   typedef logic [STEP_WIDTH-1:0] step_type;
   typedef logic [2:0]            cond_type;
   typedef logic [1:0]            verdict_type;

   // verdict codes
   localparam verdict_type VERDICT_PERFECT     = 2'd0;
   localparam verdict_type VERDICT_NOT_PERFECT = 2'd1;
   localparam verdict_type VERDICT_INVALID     = 2'd2;
   localparam verdict_type VERDICT_RESERVED    = 2'd3;

   // jump conditions
   localparam cond_type COND_NEVER     = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_NO_REQ    = 3'd2;
   localparam cond_type COND_INVALID   = 3'd3;
   localparam cond_type COND_D_GT_HALF = 3'd4;
   localparam cond_type COND_DIV_BUSY  = 3'd5;
   localparam cond_type COND_RSP_BUSY  = 3'd6;

   // program steps
   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_CHECK  = 3'd1;
   localparam step_type STEP_LOOP   = 3'd2;
   localparam step_type STEP_DIV    = 3'd3;
   localparam step_type STEP_ACC    = 3'd4;
   localparam step_type STEP_SPARE0 = 3'd5;
   localparam step_type STEP_SPARE1 = 3'd6;
   localparam step_type STEP_REPORT = 3'd7;

   typedef struct packed {
      logic     req_ready;
      logic     div_init;
      logic     div_step;
      logic     acc_add;
      logic     rsp_load;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type word;
      logic          jump;
   } seq_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic invalid;
      logic d_gt_half;
      logic div_busy;
      logic rsp_busy;
   } status_type;

   // microprogram rom: jump to target when cond holds, else fall through
   function automatic ctrl_word_type ucode_word(step_type s);
      ctrl_word_type w;
      w = '0;
      unique case (s)
         STEP_WAIT: begin
            w.req_ready = 1'b1;
            w.cond      = COND_NO_REQ;
            w.target    = STEP_WAIT;
         end
         STEP_CHECK: begin
            w.cond   = COND_INVALID;
            w.target = STEP_REPORT;
         end
         STEP_LOOP: begin
            w.div_init = 1'b1;
            w.cond     = COND_D_GT_HALF;
            w.target   = STEP_REPORT;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_BUSY;
            w.target   = STEP_DIV;
         end
         STEP_ACC: begin
            w.acc_add = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = STEP_LOOP;
         end
         STEP_REPORT: begin
            w.rsp_load = 1'b1;
            w.cond     = COND_RSP_BUSY;
            w.target   = STEP_REPORT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/pnc_sequencer.sv =====
// ----------------------------------------------------------------------------
// pnc_sequencer
// step counter, microcode rom lookup and conditional jump logic
// ----------------------------------------------------------------------------
module pnc_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  pnc_pkg::status_type   status,
   output pnc_pkg::seq_ctrl_type ctrl
);
   import pnc_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type word;
   logic          jump;

   assign word = ucode_word(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_NEVER:     jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NO_REQ:    jump = !status.req_valid;
         COND_INVALID:   jump = status.invalid;
         COND_D_GT_HALF: jump = status.d_gt_half;
         COND_DIV_BUSY:  jump = status.div_busy;
         COND_RSP_BUSY:  jump = status.rsp_busy;
         default:        jump = 1'b1;
      endcase
   end

   // fall through wraps from the report step back to the wait step
   assign step_in = jump ? word.target : STEP_WIDTH'(step_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.word = word;
   assign ctrl.jump = jump;

`ifndef SYNTH
   a_reset_to_wait: assert property (@(posedge clock) reset |=> step_ff == STEP_WAIT)
      else $error("sequencer not at wait step after reset");
   a_spare_unreached: assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_SPARE0 && step_ff != STEP_SPARE1)
      else $error("sequencer reached a spare step");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_DIV && !status.div_busy) |=> step_ff == STEP_ACC)
      else $error("remainder loop did not exit to accumulate step");
`endif

endmodule

// ===== hdl/pnc_datapath.sv =====
// ----------------------------------------------------------------------------
// pnc_datapath
// operand, trial divisor, bit-serial remainder, aliquot sum and result register
// ----------------------------------------------------------------------------
module pnc_datapath #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pnc_pkg::seq_ctrl_type        ctrl,
   input  logic                         req_valid,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output pnc_pkg::verdict_type         rsp_verdict,
   output logic [pnc_pkg::SUM_WIDTH-1:0] rsp_divisor_sum,
   output pnc_pkg::status_type          status
);
   import pnc_pkg::*;

   localparam int MAG_WIDTH = VALUE_WIDTH - 1;
   localparam int CNT_WIDTH = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;
   localparam int ACC_WIDTH = (VALUE_WIDTH + 3 > SUM_WIDTH) ? VALUE_WIDTH + 3 : SUM_WIDTH;

   logic [MAG_WIDTH-1:0] n_ff, n_in;
   logic                 invalid_ff, invalid_in;
   logic [MAG_WIDTH-1:0] d_ff, d_in;
   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [MAG_WIDTH:0]   rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   verdict_type          verdict_ff, verdict_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;

   logic                 accept;
   logic                 rsp_busy;
   logic [MAG_WIDTH:0]   trial;
   logic [MAG_WIDTH:0]   d_ext;

   assign accept   = ctrl.word.req_ready && req_valid;
   assign rsp_busy = rsp_valid_ff && !rsp_ready;
   assign d_ext    = {1'b0, d_ff};
   assign trial    = {rem_ff[MAG_WIDTH-1:0], n_ff[cnt_ff]};

   always_comb begin
      n_in         = n_ff;
      invalid_in   = invalid_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      verdict_in   = verdict_ff;
      sum_in       = sum_ff;

      if (accept) begin
         n_in       = req_value[MAG_WIDTH-1:0];
         invalid_in = (req_value == '0) || req_value[VALUE_WIDTH-1];
         d_in       = MAG_WIDTH'(1);
         acc_in     = '0;
      end

      if (ctrl.word.div_init) begin
         rem_in = '0;
         cnt_in = CNT_WIDTH'(MAG_WIDTH - 1);
      end

      // one quotient bit per step, msb first
      if (ctrl.word.div_step) begin
         rem_in = (trial >= d_ext) ? trial - d_ext : trial;
         cnt_in = cnt_ff - 1'b1;
      end

      if (ctrl.word.acc_add) begin
         if (rem_ff == '0) begin
            acc_in = acc_ff + ACC_WIDTH'(d_ff);
         end
         d_in = d_ff + 1'b1;
      end

      if (ctrl.word.rsp_load && !ctrl.jump) begin
         rsp_valid_in = 1'b1;
         sum_in       = acc_ff[SUM_WIDTH-1:0];
         if (invalid_ff) begin
            verdict_in = VERDICT_INVALID;
         end else if (acc_ff == ACC_WIDTH'(n_ff)) begin
            verdict_in = VERDICT_PERFECT;
         end else begin
            verdict_in = VERDICT_NOT_PERFECT;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      invalid_ff <= invalid_in;
      d_ff       <= d_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      verdict_ff <= verdict_in;
      sum_ff     <= sum_in;
   end

   assign status.req_valid = req_valid;
   assign status.invalid   = invalid_ff;
   assign status.d_gt_half = d_ff > (n_ff >> 1);
   assign status.div_busy  = cnt_ff != '0;
   assign status.rsp_busy  = rsp_busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_divisor_sum = sum_ff;

`ifndef SYNTH
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctrl.word.div_step |=> rem_ff < d_ext)
      else $error("partial remainder not below trial divisor");
   a_no_reserved_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> verdict_ff != VERDICT_RESERVED)
      else $error("reserved verdict code on response");
   a_invalid_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && verdict_ff == VERDICT_INVALID) |-> sum_ff == '0)
      else $error("invalid response carries a nonzero sum");
`endif

endmodule

// ===== hdl/perfect_number_check.sv =====
// ----------------------------------------------------------------------------
// perfect_number_check
// perfect number test by aliquot sum, run by a small microprogram
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_value (signed, VALUE_WIDTH)
// rsp      out        rsp_valid/rsp_ready    rsp_verdict (2), rsp_divisor_sum (18)
//
// the run time for a positive n is set by the trial divisor loop and its
//   bit-serial remainder (one bit a cycle)
// a zero or negative request skips the loop: the check step jumps to the report step
// reset clears the step counter and the response valid flag, nothing else
// a request is taken only at the wait step, one request at a time
// a stalled response holds in its register; the block may take the next
//   request while it waits, and parks at the report step only if a new one
//   finishes before the old is taken
//
module perfect_number_check #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_verdict,
   output logic [17:0]                   rsp_divisor_sum
);
   import pnc_pkg::*;

   seq_ctrl_type ctrl;     // control word of the current step plus jump flag
   status_type   status;   // datapath flags tested by jump conditions
   verdict_type  verdict;

   // program counter and microcode rom
   pnc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // operand, divider, sum and response register
   pnc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_valid       (req_valid),
      .req_value       (req_value),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_verdict     (verdict),
      .rsp_divisor_sum (rsp_divisor_sum),
      .status          (status)
   );

   // ready comes straight from the control word of the wait step
   assign req_ready   = ctrl.word.req_ready;
   assign rsp_verdict = verdict;

endmodule
